/* hw/rtl/ndef_pkg.sv */
package ndef_pkg;

    localparam logic [31:0] LONG_LEN_BYTES = 32'd4;
    localparam logic [7:0]  LAST_CTRL_CHAR = 8'd31;
    localparam logic [7:0]  DEL_CHAR       = 8'd127;

    localparam int FLAG_MB_BIT = 7;
    localparam int FLAG_ME_BIT = 6;
    localparam int FLAG_CF_BIT = 5;
    localparam int FLAG_SR_BIT = 4;
    localparam int FLAG_IL_BIT = 3;

    localparam logic [2:0] KIND_HEADER   = 3'd0;
    localparam logic [2:0] KIND_TYPE_LEN = 3'd1;
    localparam logic [2:0] KIND_PAY_LEN  = 3'd2;
    localparam logic [2:0] KIND_ID_LEN   = 3'd3;
    localparam logic [2:0] KIND_TYPE     = 3'd4;
    localparam logic [2:0] KIND_ID       = 3'd5;
    localparam logic [2:0] KIND_PAYLOAD  = 3'd6;
    localparam logic [2:0] KIND_SKIPPED  = 3'd7;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_CHAR  = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;

    typedef enum logic [6:0] {
        PH_HEADER  = 7'b0000001,
        PH_TYPELEN = 7'b0000010,
        PH_PAYLEN  = 7'b0000100,
        PH_IDLEN   = 7'b0001000,
        PH_TYPE    = 7'b0010000,
        PH_ID      = 7'b0100000,
        PH_PAYLOAD = 7'b1000000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] bytes_left;
        logic        done;
    } t_entry;

    typedef struct packed {
        logic [2:0]  field_kind;
        logic [7:0]  data_byte;
        logic [2:0]  tnf;
        logic        mb;
        logic        me;
        logic        cf;
        logic [31:0] payload_length;
        logic [7:0]  type_length;
        logic [7:0]  ident_len;
        logic        record_done;
        logic [1:0]  error_code;
    } t_result;

endpackage

/* hw/rtl/ndef_record_parser.sv */
// NDEF record parser.
// Input channel: one record byte per transfer (i_data_byte_in) with i_frame_end
// marking the last byte available in the buffer; i_in_valid / o_in_ready.
// Output channel: one result per input byte, giving the field the byte belongs
// to, the byte itself, the current header flags and lengths, a record-done
// strobe and an error code; o_out_valid / i_out_ready.
// The result of an accepted byte is valid after the accepting edge when the
// result register is free or being read. Throughput is one byte per cycle while
// o_in_ready is high, set by the single register stage holding state and result.
// A two-entry output stage (result register plus skid register) lets the
// parser take a byte while a finished result waits. When the receiver stalls
// and both entries are full, o_in_ready drops until the receiver takes one.
// Reset (i_rst_n low at a clock edge) empties the output stage and returns the
// parser to expecting a header byte with all flags and lengths cleared.
// After an invalid type character, bytes are tagged as skipped until a byte
// with i_frame_end; a frame end inside an unfinished record reports truncation.
module ndef_record_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte_in,
    input  logic        i_frame_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_field_kind,
    output logic [7:0]  o_data_byte_out,
    output logic [2:0]  o_type_name_format,
    output logic        o_message_begin,
    output logic        o_message_end,
    output logic        o_chunked,
    output logic [31:0] o_payload_length,
    output logic [7:0]  o_type_length,
    output logic [7:0]  o_id_length,
    output logic        o_record_done,
    output logic [1:0]  o_error_code
);
    import ndef_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_flags, n_flags;
    logic [7:0]  r_type_len, n_type_len;
    logic [7:0]  r_id_len, n_id_len;
    logic [31:0] r_pay_len, n_pay_len;
    logic [31:0] r_bytes_left, n_bytes_left;
    logic        r_skip, n_skip;

    t_result     r_out, r_skid, n_res;
    logic        r_out_valid, r_skid_valid;

    logic        accept, pop;
    logic [2:0]  kind;
    logic [1:0]  err;
    logic        done;
    logic [31:0] bl_dec;
    t_entry      entry;

    function automatic t_entry f_enter(
        input logic        allow_type,
        input logic        allow_id,
        input logic [7:0]  tl,
        input logic [7:0]  il,
        input logic [31:0] pl
    );
        t_entry e;
        e.done = 1'b0;
        if (allow_type && (tl != 8'd0)) begin
            e.phase      = PH_TYPE;
            e.bytes_left = {24'd0, tl};
        end else if (allow_id && (il != 8'd0)) begin
            e.phase      = PH_ID;
            e.bytes_left = {24'd0, il};
        end else if (pl != 32'd0) begin
            e.phase      = PH_PAYLOAD;
            e.bytes_left = pl;
        end else begin
            e.phase      = PH_HEADER;
            e.bytes_left = 32'd0;
            e.done       = 1'b1;
        end
        return e;
    endfunction

    assign accept = i_in_valid && o_in_ready;
    assign pop    = r_out_valid && i_out_ready;

    always_comb begin
        n_phase      = r_phase;
        n_flags      = r_flags;
        n_type_len   = r_type_len;
        n_id_len     = r_id_len;
        n_pay_len    = r_pay_len;
        n_bytes_left = r_bytes_left;
        n_skip       = r_skip;
        kind         = KIND_SKIPPED;
        err          = ERR_NONE;
        done         = 1'b0;
        bl_dec       = (r_bytes_left != 32'd0) ? (r_bytes_left - 32'd1) : 32'd0;
        entry        = '{phase: PH_HEADER, bytes_left: 32'd0, done: 1'b0};

        if (r_skip) begin
            if (i_frame_end) begin
                n_skip  = 1'b0;
                n_phase = PH_HEADER;
            end
        end else begin
            case (r_phase)
                PH_HEADER: begin
                    kind         = KIND_HEADER;
                    n_flags      = i_data_byte_in;
                    n_type_len   = 8'd0;
                    n_id_len     = 8'd0;
                    n_pay_len    = 32'd0;
                    n_bytes_left = 32'd0;
                    n_phase      = PH_TYPELEN;
                end
                PH_TYPELEN: begin
                    kind         = KIND_TYPE_LEN;
                    n_type_len   = i_data_byte_in;
                    n_bytes_left = r_flags[FLAG_SR_BIT] ? 32'd1 : LONG_LEN_BYTES;
                    n_phase      = PH_PAYLEN;
                end
                PH_PAYLEN: begin
                    kind         = KIND_PAY_LEN;
                    n_pay_len    = {r_pay_len[23:0], i_data_byte_in};
                    n_bytes_left = bl_dec;
                    if (bl_dec == 32'd0) begin
                        if (r_flags[FLAG_IL_BIT]) begin
                            n_phase = PH_IDLEN;
                        end else begin
                            entry        = f_enter(1'b1, 1'b1, r_type_len, r_id_len,
                                                   n_pay_len);
                            n_phase      = entry.phase;
                            n_bytes_left = entry.bytes_left;
                            done         = entry.done;
                        end
                    end
                end
                PH_IDLEN: begin
                    kind         = KIND_ID_LEN;
                    n_id_len     = i_data_byte_in;
                    entry        = f_enter(1'b1, 1'b1, r_type_len, i_data_byte_in,
                                           r_pay_len);
                    n_phase      = entry.phase;
                    n_bytes_left = entry.bytes_left;
                    done         = entry.done;
                end
                PH_TYPE: begin
                    kind = KIND_TYPE;
                    if ((i_data_byte_in <= LAST_CTRL_CHAR) || (i_data_byte_in == DEL_CHAR)) begin
                        err = ERR_BAD_CHAR;
                    end else begin
                        n_bytes_left = bl_dec;
                        if (bl_dec == 32'd0) begin
                            entry        = f_enter(1'b0, 1'b1, r_type_len, r_id_len,
                                                   r_pay_len);
                            n_phase      = entry.phase;
                            n_bytes_left = entry.bytes_left;
                            done         = entry.done;
                        end
                    end
                end
                PH_ID: begin
                    kind         = KIND_ID;
                    n_bytes_left = bl_dec;
                    if (bl_dec == 32'd0) begin
                        entry        = f_enter(1'b0, 1'b0, r_type_len, r_id_len, r_pay_len);
                        n_phase      = entry.phase;
                        n_bytes_left = entry.bytes_left;
                        done         = entry.done;
                    end
                end
                PH_PAYLOAD: begin
                    kind         = KIND_PAYLOAD;
                    n_bytes_left = bl_dec;
                    if (bl_dec == 32'd0) begin
                        n_phase = PH_HEADER;
                        done    = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase

            if (err == ERR_BAD_CHAR) begin
                if (i_frame_end) begin
                    n_phase = PH_HEADER;
                end else begin
                    n_skip = 1'b1;
                end
            end else if (i_frame_end && !done) begin
                err     = ERR_TRUNCATED;
                n_phase = PH_HEADER;
            end
        end

        n_res.field_kind     = kind;
        n_res.data_byte      = i_data_byte_in;
        n_res.tnf            = n_flags[2:0];
        n_res.mb             = n_flags[FLAG_MB_BIT];
        n_res.me             = n_flags[FLAG_ME_BIT];
        n_res.cf             = n_flags[FLAG_CF_BIT];
        n_res.payload_length = n_pay_len;
        n_res.type_length    = n_type_len;
        n_res.ident_len      = n_id_len;
        n_res.record_done    = done;
        n_res.error_code     = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_flags      <= 8'd0;
            r_type_len   <= 8'd0;
            r_id_len     <= 8'd0;
            r_pay_len    <= 32'd0;
            r_bytes_left <= 32'd0;
            r_skip       <= 1'b0;
        end else if (accept) begin
            r_phase      <= n_phase;
            r_flags      <= n_flags;
            r_type_len   <= n_type_len;
            r_id_len     <= n_id_len;
            r_pay_len    <= n_pay_len;
            r_bytes_left <= n_bytes_left;
            r_skip       <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= n_res;
            end
        end else if (accept) begin
            r_skid <= n_res;
        end
    end

    assign o_in_ready         = !r_skid_valid;
    assign o_out_valid        = r_out_valid;
    assign o_field_kind       = r_out.field_kind;
    assign o_data_byte_out    = r_out.data_byte;
    assign o_type_name_format = r_out.tnf;
    assign o_message_begin    = r_out.mb;
    assign o_message_end      = r_out.me;
    assign o_chunked          = r_out.cf;
    assign o_payload_length   = r_out.payload_length;
    assign o_type_length      = r_out.type_length;
    assign o_id_length        = r_out.ident_len;
    assign o_record_done      = r_out.record_done;
    assign o_error_code       = r_out.error_code;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while result register is empty");

    a_skip_in_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> (r_phase == PH_TYPE))
        else $error("skipping outside of a type field");

    a_body_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_TYPE) || (r_phase == PH_ID) || (r_phase == PH_PAYLOAD))
            |-> (r_bytes_left != 32'd0))
        else $error("body field entered with no bytes left");

    a_err_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_error_code != ERR_NONE)) |-> !o_record_done)
        else $error("record reported both done and in error");

endmodule

/* tb/tb_ndef_record_parser.sv */
module tb_ndef_record_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import ndef_pkg::*;

    typedef enum logic [2:0] {
        AT_HEADER,
        AT_TYPE_LEN,
        AT_PAY_LEN,
        AT_ID_LEN,
        AT_TYPE,
        AT_ID,
        AT_PAYLOAD
    } t_stage;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte_in;
    logic        i_frame_end;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_field_kind;
    logic [7:0]  o_data_byte_out;
    logic [2:0]  o_type_name_format;
    logic        o_message_begin;
    logic        o_message_end;
    logic        o_chunked;
    logic [31:0] o_payload_length;
    logic [7:0]  o_type_length;
    logic [7:0]  o_id_length;
    logic        o_record_done;
    logic [1:0]  o_error_code;

    t_stage      rec_phase;
    logic [7:0]  rec_flags;
    logic [7:0]  rec_type_len;
    logic [7:0]  rec_id_len;
    logic [31:0] rec_pay_len;
    logic [31:0] field_remaining;
    logic        skipping_to_end;

    t_result     pending_results[$];
    int          sent_count;
    int          mismatch_count;
    bit          steady;

    ndef_record_parser uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_data_byte_in     (i_data_byte_in),
        .i_frame_end        (i_frame_end),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_field_kind       (o_field_kind),
        .o_data_byte_out    (o_data_byte_out),
        .o_type_name_format (o_type_name_format),
        .o_message_begin    (o_message_begin),
        .o_message_end      (o_message_end),
        .o_chunked          (o_chunked),
        .o_payload_length   (o_payload_length),
        .o_type_length      (o_type_length),
        .o_id_length        (o_id_length),
        .o_record_done      (o_record_done),
        .o_error_code       (o_error_code)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Moves to the first non-empty body field at or after the given one.
    function automatic logic enter_field(t_stage from);
        if (from <= AT_TYPE && rec_type_len != 8'd0) begin
            rec_phase = AT_TYPE;
            field_remaining = 32'(rec_type_len);
            return 1'b0;
        end
        if (from <= AT_ID && rec_id_len != 8'd0) begin
            rec_phase = AT_ID;
            field_remaining = 32'(rec_id_len);
            return 1'b0;
        end
        if (rec_pay_len != 32'd0) begin
            rec_phase = AT_PAYLOAD;
            field_remaining = rec_pay_len;
            return 1'b0;
        end
        rec_phase = AT_HEADER;
        field_remaining = 32'd0;
        return 1'b1;
    endfunction

    function automatic logic count_field(t_stage next, bit is_last);
        if (field_remaining != 32'd0) field_remaining--;
        if (field_remaining != 32'd0) return 1'b0;
        if (is_last) begin
            rec_phase = AT_HEADER;
            return 1'b1;
        end
        return enter_field(next);
    endfunction

    function automatic t_result parse_byte(logic [7:0] b, logic fe);
        t_result    r;
        logic [2:0] kind;
        logic       done;
        logic [1:0] err;
        kind = KIND_SKIPPED;
        done = 1'b0;
        err = ERR_NONE;
        if (skipping_to_end) begin
            if (fe) begin
                skipping_to_end = 1'b0;
                rec_phase = AT_HEADER;
            end
        end else begin
            case (rec_phase)
                AT_HEADER: begin
                    kind = KIND_HEADER;
                    rec_flags = b;
                    rec_type_len = 8'd0;
                    rec_id_len = 8'd0;
                    rec_pay_len = 32'd0;
                    field_remaining = 32'd0;
                    rec_phase = AT_TYPE_LEN;
                end
                AT_TYPE_LEN: begin
                    kind = KIND_TYPE_LEN;
                    rec_type_len = b;
                    field_remaining = rec_flags[FLAG_SR_BIT] ? 32'd1 : LONG_LEN_BYTES;
                    rec_phase = AT_PAY_LEN;
                end
                AT_PAY_LEN: begin
                    kind = KIND_PAY_LEN;
                    rec_pay_len = {rec_pay_len[23:0], b};
                    if (field_remaining != 32'd0) field_remaining--;
                    if (field_remaining == 32'd0) begin
                        if (rec_flags[FLAG_IL_BIT]) rec_phase = AT_ID_LEN;
                        else done = enter_field(AT_TYPE);
                    end
                end
                AT_ID_LEN: begin
                    kind = KIND_ID_LEN;
                    rec_id_len = b;
                    done = enter_field(AT_TYPE);
                end
                AT_TYPE: begin
                    kind = KIND_TYPE;
                    if (b <= LAST_CTRL_CHAR || b == DEL_CHAR) err = ERR_BAD_CHAR;
                    else done = count_field(AT_ID, 1'b0);
                end
                AT_ID: begin
                    kind = KIND_ID;
                    done = count_field(AT_PAYLOAD, 1'b0);
                end
                AT_PAYLOAD: begin
                    kind = KIND_PAYLOAD;
                    done = count_field(AT_PAYLOAD, 1'b1);
                end
                default: begin
                    rec_phase = AT_HEADER;
                end
            endcase
            if (err == ERR_BAD_CHAR) begin
                if (fe) rec_phase = AT_HEADER;
                else skipping_to_end = 1'b1;
            end else if (fe && !done) begin
                err = ERR_TRUNCATED;
                rec_phase = AT_HEADER;
            end
        end
        r.field_kind = kind;
        r.data_byte = b;
        r.tnf = rec_flags[2:0];
        r.mb = rec_flags[FLAG_MB_BIT];
        r.me = rec_flags[FLAG_ME_BIT];
        r.cf = rec_flags[FLAG_CF_BIT];
        r.payload_length = rec_pay_len;
        r.type_length = rec_type_len;
        r.ident_len = rec_id_len;
        r.record_done = done;
        r.error_code = err;
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fe);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte_in <= b;
        i_frame_end <= fe;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.insert(pending_results.size(), parse_byte(b, fe));
        sent_count++;
    endtask

    // A well-formed record with random content; sometimes it carries a bad
    // type character or is cut short by a frame end.
    task automatic send_record();
        logic [7:0]  flags;
        logic [7:0]  tlen;
        logic [7:0]  ilen;
        logic [31:0] plen;
        logic [7:0]  body[$];
        logic [7:0]  b;
        int          n_len;
        int          cut;
        int          i;
        bit          bad;
        bit          close;
        flags = 8'($urandom_range(0, 255));
        flags[FLAG_SR_BIT] = ($urandom_range(0, 3) != 0);
        tlen = ($urandom_range(0, 40) == 0) ? 8'($urandom_range(100, 255))
                                           : 8'($urandom_range(0, 4));
        ilen = flags[FLAG_IL_BIT] ? 8'($urandom_range(0, 3)) : 8'd0;
        if (flags[FLAG_SR_BIT]) begin
            plen = ($urandom_range(0, 40) == 0) ? $urandom_range(100, 255)
                                               : $urandom_range(0, 10);
        end else begin
            plen = ($urandom_range(0, 30) == 0) ? $urandom_range(256, 600)
                                               : $urandom_range(0, 12);
        end
        body.insert(body.size(), flags);
        body.insert(body.size(), tlen);
        if (flags[FLAG_SR_BIT]) begin
            body.insert(body.size(), plen[7:0]);
        end else begin
            for (i = 3; i >= 0; i--) body.insert(body.size(), plen[8*i +: 8]);
        end
        if (flags[FLAG_IL_BIT]) body.insert(body.size(), ilen);
        n_len = body.size();
        for (i = 0; i < tlen; i++) begin
            do b = 8'($urandom_range(32, 255)); while (b == DEL_CHAR);
            body.insert(body.size(), b);
        end
        for (i = 0; i < ilen; i++) body.insert(body.size(), 8'($urandom_range(0, 255)));
        for (i = 0; i < plen; i++) body.insert(body.size(), 8'($urandom_range(0, 255)));
        bad = (tlen != 8'd0) && ($urandom_range(0, 7) == 0);
        if (bad) begin
            body[n_len + $urandom_range(0, tlen - 1)] =
                ($urandom_range(0, 4) == 0) ? DEL_CHAR : 8'($urandom_range(0, 31));
        end
        cut = body.size() - 1;
        close = bad || ($urandom_range(0, 1) == 0);
        if (!bad && $urandom_range(0, 7) == 0) begin
            cut = $urandom_range(0, body.size() - 1);
            close = 1'b1;
        end
        steady = ($urandom_range(0, 5) == 0);
        for (i = 0; i <= cut; i++) send_byte(body[i], close && (i == cut));
        steady = 1'b0;
    endtask

    task automatic test_directed_records();
        // Short record with an ID, lowest printable type character.
        send_byte(8'hD9, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7E, 1'b1);
        // Record with all three fields empty completes on its length byte.
        send_byte(8'h10, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        // Maximum long-form length, truncated on the last length byte.
        send_byte(8'h27, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // Delete character in the type, then skipped bytes up to frame end.
        send_byte(8'h11, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(DEL_CHAR, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        // Control character in the type on the frame's last byte.
        send_byte(8'h11, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(LAST_CTRL_CHAR, 1'b1);
    endtask

    task automatic test_random_records(input int target);
        while (sent_count < target) send_record();
    endtask

    task automatic test_long_lengths();
        logic [7:0]  flags;
        logic [31:0] plen;
        int          n;
        int          i;
        repeat (30) begin
            flags = 8'($urandom_range(0, 255));
            flags[FLAG_SR_BIT] = 1'b0;
            flags[FLAG_IL_BIT] = 1'b0;
            plen = $urandom() | 32'h10;
            send_byte(flags, 1'b0);
            send_byte(8'h00, 1'b0);
            for (i = 3; i >= 0; i--) send_byte(plen[8*i +: 8], 1'b0);
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), i == n - 1);
        end
    endtask

    task automatic test_noise();
        repeat (150) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin
        int stall;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = {o_field_kind, o_data_byte_out, o_type_name_format, o_message_begin,
                    o_message_end, o_chunked, o_payload_length, o_type_length,
                    o_id_length, o_record_done, o_error_code};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transfer: kind %0d byte %h err %0d",
                             seen.field_kind, seen.data_byte, seen.error_code);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (seen !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch exp: kind %0d byte %h tnf %0d mb %b me %b cf %b",
                                 want.field_kind, want.data_byte, want.tnf, want.mb,
                                 want.me, want.cf);
                        $display("    plen %h tlen %0d ilen %0d done %b err %0d",
                                 want.payload_length, want.type_length, want.ident_len,
                                 want.record_done, want.error_code);
                        $display("         got: kind %0d byte %h tnf %0d mb %b me %b cf %b",
                                 seen.field_kind, seen.data_byte, seen.tnf, seen.mb,
                                 seen.me, seen.cf);
                        $display("    plen %h tlen %0d ilen %0d done %b err %0d",
                                 seen.payload_length, seen.type_length, seen.ident_len,
                                 seen.record_done, seen.error_code);
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        rec_phase = AT_HEADER;
        rec_flags = 8'd0;
        rec_type_len = 8'd0;
        rec_id_len = 8'd0;
        rec_pay_len = 32'd0;
        field_remaining = 32'd0;
        skipping_to_end = 1'b0;
        sent_count = 0;
        mismatch_count = 0;
        steady = 1'b0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_data_byte_in <= 8'd0;
        i_frame_end <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_records();
        test_random_records(400);
        test_long_lengths();
        test_noise();
        test_random_records(850);

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/ndef_pkg.sv
hw/rtl/ndef_record_parser.sv
tb/tb_ndef_record_parser.sv
